// ===== rtl/kpsdr_pkg.sv =====
// package: beat types, register indexes, commands, reset values and the scan code tables of the keypad scanner
package kpsdr_pkg;

    // number of legal scan codes (single keys and rollover pairs)
    localparam int NUM_CODES = 20;

    // register indexes of the configuration port
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_REPEAT   = 1'b1;

    // input commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // reset values of the tick registers
    localparam logic [15:0] DEBOUNCE_RESET = 16'd10000;
    localparam logic [15:0] REPEAT_RESET   = 16'd5000;

    // legal scan codes: row bits in the high nibble, column bits in the low nibble
    localparam logic [7:0] LEGAL_SCAN [NUM_CODES] = '{
        8'h11, 8'h21, 8'h41, 8'h81,
        8'h12, 8'h22, 8'h42, 8'h82,
        8'h14, 8'h24, 8'h44, 8'h84,
        8'h18, 8'h28, 8'h48, 8'h88,
        8'hC3, 8'hC6, 8'h63, 8'h66
    };

    // key codes that go with each legal scan code
    localparam logic [7:0] LEGAL_KEY [NUM_CODES] = '{
        8'h0B, 8'h39, 8'h38, 8'h37,
        8'h1B, 8'h36, 8'h35, 8'h34,
        8'h18, 8'h33, 8'h32, 8'h31,
        8'h0D, 8'h2D, 8'h2B, 8'h30,
        8'h73, 8'h74, 8'h71, 8'h72
    };

    // input beat
    typedef struct packed {
        logic        command;
        logic [15:0] key_matrix;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0] key_code;
        logic [1:0] phase;
    } t_out_beat;

endpackage

// ===== rtl/keypad_scan_debounce_repeat.sv =====
// top level: 4x4 keypad scanner with debounce, repeat rescans and bus read
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  in       | i_in_valid, o_in_stall, i_in          | to block
//  out      | o_out_valid, i_out_stall, o_out       | from block
//  cfg      | i_cfg_we, i_cfg_index, i_cfg_data     | to block
//
//  one beat per cycle while out is not stalled; an accepted beat moves through the
//  input register, then table match and state update into the result register
//  i_rst_n is synchronous and active low; it restores the tick registers to their reset values
//  a stalled result holds the result register; the input register still takes one more beat
//  o_in_stall rises only when both the input and result registers are full and out is stalled
module keypad_scan_debounce_repeat (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kpsdr_pkg::t_in_beat  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kpsdr_pkg::t_out_beat o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2
    } t_phase;

    // configuration registers
    logic [15:0] r_debounce_ticks;
    logic [15:0] r_repeat_ticks;

    // input register
    logic                r_s1_valid;
    kpsdr_pkg::t_in_beat r_s1;

    // scanner state
    t_phase      r_phase,     n_phase;
    logic [15:0] r_tick,      n_tick;
    logic [7:0]  r_cand,      n_cand;
    logic [7:0]  r_held_code, n_held_code;
    logic [3:0]  r_prev_cols, n_prev_cols;

    // result register
    logic                 r_out_valid;
    kpsdr_pkg::t_out_beat r_out;

    logic       w_adv;
    logic       w_fire;
    logic       w_in_acc;
    logic [3:0] w_cols;
    logic [7:0] w_key;
    logic [3:0] w_rising;
    logic [16:0] w_next;

    // handshake control
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign w_fire     = r_s1_valid && w_adv;
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= kpsdr_pkg::DEBOUNCE_RESET;
            r_repeat_ticks   <= kpsdr_pkg::REPEAT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kpsdr_pkg::REG_DEBOUNCE: r_debounce_ticks <= i_cfg_data;
                kpsdr_pkg::REG_REPEAT:   r_repeat_ticks   <= i_cfg_data;
                default:                 r_repeat_ticks   <= r_repeat_ticks;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_s1 <= i_in;
        end
    end

    kpsdr_decode u_decode (
        .i_matrix   (r_s1.key_matrix),
        .o_columns  (w_cols),
        .o_key_code (w_key)
    );

    assign w_rising = w_cols & ~r_prev_cols;
    assign w_next   = {1'b0, r_tick} + 17'd1;

    // next state for one tick beat
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_cand      = r_cand;
        n_held_code = r_held_code;
        n_prev_cols = r_prev_cols;
        if (r_s1.command == kpsdr_pkg::CMD_TICK) begin
            n_prev_cols = w_cols;
            unique case (r_phase)
                PH_DEBOUNCE: begin
                    if (w_next >= {1'b0, r_debounce_ticks}) begin
                        n_tick = '0;
                        if (w_key != 8'h00 && w_key == r_cand) begin
                            n_held_code = w_key;
                            n_phase     = PH_HELD;
                        end else begin
                            n_held_code = 8'h00;
                            n_phase     = PH_IDLE;
                        end
                    end else begin
                        n_tick = w_next[15:0];
                    end
                end
                PH_HELD: begin
                    if (w_next >= {1'b0, r_repeat_ticks}) begin
                        n_tick      = '0;
                        n_held_code = w_key;
                        if (w_key == 8'h00) begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_tick = w_next[15:0];
                    end
                end
                default: begin
                    // idle, and the unused code acting as idle
                    n_phase     = PH_IDLE;
                    n_held_code = 8'h00;
                    n_tick      = '0;
                    if (w_rising != 4'h0 && w_key != 8'h00) begin
                        n_cand  = w_key;
                        n_phase = PH_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_cand      <= 8'h00;
            r_held_code <= 8'h00;
            r_prev_cols <= 4'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_cand      <= n_cand;
                r_held_code <= n_held_code;
                r_prev_cols <= n_prev_cols;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_fire) begin
            r_out.key_code <= n_held_code;
            r_out.phase    <= n_phase;
        end
    end

    // checks on the scanner state
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.phase != 2'd3)
        else $error("result phase out of range");

    a_held_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HELD |-> r_held_code != 8'h00)
        else $error("held phase with empty key code");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_held_code == 8'h00 && r_tick == 16'd0))
        else $error("idle phase with stale code or count");

    a_cand_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DEBOUNCE |-> r_cand != 8'h00)
        else $error("debounce with empty candidate");

    a_read_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_s1.command == kpsdr_pkg::CMD_READ) |=>
            (r_out.key_code == $past(r_held_code) && r_held_code == $past(r_held_code)))
        else $error("bus read changed the key code");

endmodule

// ===== rtl/kpsdr_decode.sv =====
// module: matrix snapshot to column bits and key code
module kpsdr_decode (
    input  logic [15:0] i_matrix,
    output logic [3:0]  o_columns,
    output logic [7:0]  o_key_code
);

    logic [3:0] w_rows;
    logic [7:0] w_scan;

    // or of the columns over all rows, and one bit per busy row
    always_comb begin
        o_columns = i_matrix[3:0] | i_matrix[7:4] | i_matrix[11:8] | i_matrix[15:12];
        for (int r = 0; r < 4; r++) begin
            w_rows[r] = |i_matrix[r*4 +: 4];
        end
        w_scan = {w_rows, o_columns};
    end

    // match against the legal code table, no match gives 0
    always_comb begin
        o_key_code = 8'h00;
        for (int k = 0; k < kpsdr_pkg::NUM_CODES; k++) begin
            if (w_scan == kpsdr_pkg::LEGAL_SCAN[k]) begin
                o_key_code = kpsdr_pkg::LEGAL_KEY[k];
            end
        end
    end

endmodule
